### hdl/bds_pkg.sv
// Shared types, codes and reset values for the battery discharge supervisor.
// Used by the channel interfaces, the step logic and the top level.
package bds_pkg;

    localparam int unsigned THRESH_W = 12;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 12;

    localparam int unsigned LED_LOW_COUNT_DEF       = 10;
    localparam int unsigned HEAVY_RELEASE_COUNT_DEF = 10;
    localparam int unsigned LIGHT_LOAD_COUNT_DEF    = 10;

    localparam logic OP_ENTER  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] VERDICT_STAY      = 2'd0;
    localparam logic [1:0] VERDICT_POWER_OFF = 2'd1;
    localparam logic [1:0] VERDICT_SAFETY    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_LED_LOW_TH       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAVY_CUTOFF_TH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VIN_CUTOFF_TH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BAT_CUTOFF_TH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_HIGH_TH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_LOW_TH   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAVY_CUTOFF_CNT = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_CUTOFF_CNT = 3'd7;

    typedef struct packed {
        logic                operation;
        logic [THRESH_W-1:0] battery_code;
        logic [THRESH_W-1:0] current_code;
        logic                input_was_present;
    } sample_t;

    typedef struct packed {
        logic       led_low_on;
        logic       led_load_on;
        logic       high_load;
        logic       low_current;
        logic       low_voltage;
        logic [1:0] verdict;
    } result_t;

    typedef struct packed {
        logic [THRESH_W-1:0] led_low_threshold;
        logic [THRESH_W-1:0] heavy_cutoff_threshold;
        logic [THRESH_W-1:0] vin_cutoff_threshold;
        logic [THRESH_W-1:0] battery_cutoff_threshold;
        logic [THRESH_W-1:0] current_high_threshold;
        logic [THRESH_W-1:0] current_low_threshold;
        logic [COUNT_W-1:0]  heavy_cutoff_count;
        logic [COUNT_W-1:0]  light_cutoff_count;
    } cfg_t;

    typedef struct packed {
        logic led_low;
        logic led_load;
        logic high_load;
        logic low_current;
        logic low_voltage;
    } flags_t;

    typedef struct packed {
        logic [COUNT_W-1:0] led_low_counter;
        logic [COUNT_W-1:0] heavy_release_counter;
        logic [COUNT_W-1:0] light_load_counter;
        logic [COUNT_W-1:0] heavy_undervolt_counter;
        logic [COUNT_W-1:0] light_undervolt_counter;
        flags_t             flags;
    } state_t;

    localparam flags_t FLAGS_CLEAR = '{
        led_low: 1'b0, led_load: 1'b1, high_load: 1'b0,
        low_current: 1'b0, low_voltage: 1'b0
    };

    localparam state_t STATE_CLEAR = '{
        led_low_counter: '0, heavy_release_counter: '0, light_load_counter: '0,
        heavy_undervolt_counter: '0, light_undervolt_counter: '0,
        flags: FLAGS_CLEAR
    };

    localparam cfg_t CFG_RESET = '{
        led_low_threshold: '0, heavy_cutoff_threshold: '0,
        vin_cutoff_threshold: '0, battery_cutoff_threshold: '0,
        current_high_threshold: '0, current_low_threshold: '0,
        heavy_cutoff_count: 8'd10, light_cutoff_count: 8'd10
    };

endpackage

### hdl/bds_sample_if.sv
// Valid/ready channel carrying one input item of the supervisor.
// Depends on bds_pkg for the payload type.
interface bds_sample_if;
    logic             valid;
    logic             ready;
    bds_pkg::sample_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/bds_result_if.sv
// Valid/ready channel carrying one result item of the supervisor.
// Depends on bds_pkg for the payload type.
interface bds_result_if;
    logic             valid;
    logic             ready;
    bds_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/bds_step.sv
// Next-state and result logic for one item: debounce counters, flags, verdict.
// Depends on bds_pkg; purely combinational.
module bds_step #(
    parameter int unsigned LED_LOW_COUNT       = bds_pkg::LED_LOW_COUNT_DEF,
    parameter int unsigned HEAVY_RELEASE_COUNT = bds_pkg::HEAVY_RELEASE_COUNT_DEF,
    parameter int unsigned LIGHT_LOAD_COUNT    = bds_pkg::LIGHT_LOAD_COUNT_DEF
) (
    input  bds_pkg::cfg_t    cfg,
    input  bds_pkg::state_t  state,
    input  bds_pkg::sample_t sample,
    output bds_pkg::state_t  state_next,
    output bds_pkg::result_t result
);
    import bds_pkg::*;

    localparam logic [COUNT_W-1:0] LED_LOW_LIMIT   = COUNT_W'(LED_LOW_COUNT);
    localparam logic [COUNT_W-1:0] HEAVY_REL_LIMIT = COUNT_W'(HEAVY_RELEASE_COUNT);
    localparam logic [COUNT_W-1:0] LIGHT_LD_LIMIT  = COUNT_W'(LIGHT_LOAD_COUNT);

    logic [COUNT_W-1:0]  led_inc;
    logic [COUNT_W-1:0]  rel_inc;
    logic [COUNT_W-1:0]  light_inc;
    logic [COUNT_W-1:0]  heavy_uv_inc;
    logic [COUNT_W-1:0]  light_uv_inc;
    logic [THRESH_W-1:0] light_cut;
    state_t              s;
    logic [1:0]          verdict;

    assign led_inc      = state.led_low_counter + 1'b1;
    assign rel_inc      = state.heavy_release_counter + 1'b1;
    assign light_inc    = state.light_load_counter + 1'b1;
    assign heavy_uv_inc = state.heavy_undervolt_counter + 1'b1;
    assign light_uv_inc = state.light_undervolt_counter + 1'b1;
    assign light_cut    = sample.input_was_present ? cfg.vin_cutoff_threshold
                                                   : cfg.battery_cutoff_threshold;

    always_comb
    begin
        s       = state;
        verdict = VERDICT_STAY;
        if (sample.operation == OP_ENTER)
        begin
            s = STATE_CLEAR;
        end
        else
        begin
            // low-battery LED
            if (sample.battery_code <= cfg.led_low_threshold)
            begin
                s.led_low_counter = led_inc;
                if (led_inc >= LED_LOW_LIMIT)
                begin
                    s.led_low_counter = '0;
                    s.flags.led_low   = 1'b1;
                    s.flags.led_load  = 1'b0;
                end
            end
            else
            begin
                s.led_low_counter = '0;
                s.flags.led_low   = 1'b0;
                s.flags.led_load  = 1'b1;
            end

            // heavy load sets at once, releases after debounce
            if (sample.current_code < cfg.current_high_threshold)
            begin
                s.heavy_release_counter = rel_inc;
                if (rel_inc > HEAVY_REL_LIMIT)
                begin
                    s.heavy_release_counter = '0;
                    s.flags.high_load       = 1'b0;
                end
            end
            else
            begin
                s.heavy_release_counter = '0;
                s.flags.high_load       = 1'b1;
            end

            // light load
            if (sample.current_code < cfg.current_low_threshold)
            begin
                s.light_load_counter = light_inc;
                if (light_inc > LIGHT_LD_LIMIT)
                begin
                    s.light_load_counter = '0;
                    s.flags.low_current  = 1'b1;
                end
            end
            else
            begin
                s.light_load_counter = '0;
                s.flags.low_current  = 1'b0;
            end

            // undervoltage, threshold chosen by the updated load flag
            if (s.flags.high_load)
            begin
                s.light_undervolt_counter = '0;
                if (sample.battery_code < cfg.heavy_cutoff_threshold)
                begin
                    s.heavy_undervolt_counter = heavy_uv_inc;
                    if (heavy_uv_inc >= cfg.heavy_cutoff_count)
                    begin
                        s.heavy_undervolt_counter = '0;
                        s.flags.low_voltage       = 1'b1;
                    end
                end
                else
                begin
                    s.heavy_undervolt_counter = '0;
                    s.flags.low_voltage       = 1'b0;
                end
            end
            else
            begin
                s.heavy_undervolt_counter = '0;
                if (sample.battery_code < light_cut)
                begin
                    s.light_undervolt_counter = light_uv_inc;
                    if (light_uv_inc >= cfg.light_cutoff_count)
                    begin
                        s.light_undervolt_counter = '0;
                        s.flags.low_voltage       = 1'b1;
                    end
                end
                else
                begin
                    s.light_undervolt_counter = '0;
                    s.flags.low_voltage       = 1'b0;
                end
            end

            if (s.flags.low_voltage && s.flags.high_load)
            begin
                verdict = VERDICT_SAFETY;
            end
            else if (s.flags.low_voltage && s.flags.low_current)
            begin
                verdict = VERDICT_POWER_OFF;
            end
        end
    end

    assign state_next = s;

    assign result.led_low_on  = s.flags.led_low;
    assign result.led_load_on = s.flags.led_load;
    assign result.high_load   = s.flags.high_load;
    assign result.low_current = s.flags.low_current;
    assign result.low_voltage = s.flags.low_voltage;
    assign result.verdict     = verdict;

endmodule

### hdl/battery_discharge_supervisor.sv
// Battery discharge supervisor: top level with config registers, state and output buffering.
// Depends on bds_pkg, bds_sample_if, bds_result_if and bds_step.
//
// Usage:
//   sample: input channel (valid/ready). operation 0 enters discharge mode and
//     clears all counters and flags (load LED set); operation 1 is an ADC pair.
//   result: output channel, exactly one transfer per sample transfer, in order.
//   cfg_write/cfg_index/cfg_data: register write, taken on any edge with cfg_write
//     high; write only while no result is outstanding.
// Output: each result is registered, in the skid buffer if the output register is full.
// Throughput: one sample per cycle while sample.ready is high; the state update is a single
//   pass of compares and 8-bit counter increments between the state and result registers.
// Stall: results go to an output register backed by a one-entry skid buffer, so
//   a sample is still taken while one result waits; sample.ready drops only when
//   both are full and returns once the receiver takes a result.
// Reset: thresholds clear to zero, cutoff counts to 10, counters clear, only the
//   load LED flag is set, and both output buffers empty.
module battery_discharge_supervisor #(
    parameter int unsigned LED_LOW_COUNT       = bds_pkg::LED_LOW_COUNT_DEF,
    parameter int unsigned HEAVY_RELEASE_COUNT = bds_pkg::HEAVY_RELEASE_COUNT_DEF,
    parameter int unsigned LIGHT_LOAD_COUNT    = bds_pkg::LIGHT_LOAD_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bds_sample_if.sink                         sample,
    bds_result_if.source                       result,
    input  logic                               cfg_write,
    input  logic [bds_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bds_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bds_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    state_t  state_reg;
    state_t  state_next;
    result_t step_result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    logic    accept;
    logic    take;

    bds_step #(
        .LED_LOW_COUNT       (LED_LOW_COUNT),
        .HEAVY_RELEASE_COUNT (HEAVY_RELEASE_COUNT),
        .LIGHT_LOAD_COUNT    (LIGHT_LOAD_COUNT)
    ) u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .sample     (sample.payload),
        .state_next (state_next),
        .result     (step_result)
    );

    assign sample.ready   = !skid_valid_reg;
    assign accept         = sample.valid && !skid_valid_reg;
    assign take           = out_valid_reg && result.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LED_LOW_TH:       cfg_next.led_low_threshold        = cfg_data[THRESH_W-1:0];
                REG_HEAVY_CUTOFF_TH:  cfg_next.heavy_cutoff_threshold   = cfg_data[THRESH_W-1:0];
                REG_VIN_CUTOFF_TH:    cfg_next.vin_cutoff_threshold     = cfg_data[THRESH_W-1:0];
                REG_BAT_CUTOFF_TH:    cfg_next.battery_cutoff_threshold = cfg_data[THRESH_W-1:0];
                REG_CURRENT_HIGH_TH:  cfg_next.current_high_threshold   = cfg_data[THRESH_W-1:0];
                REG_CURRENT_LOW_TH:   cfg_next.current_low_threshold    = cfg_data[THRESH_W-1:0];
                REG_HEAVY_CUTOFF_CNT: cfg_next.heavy_cutoff_count       = cfg_data[COUNT_W-1:0];
                REG_LIGHT_CUTOFF_CNT: cfg_next.light_cutoff_count       = cfg_data[COUNT_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        if (take)
        begin
            out_valid_next  = skid_valid_reg || accept;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next  = out_valid_reg || accept;
            skid_valid_next = skid_valid_reg || (accept && out_valid_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= CFG_RESET;
            state_reg      <= STATE_CLEAR;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= step_result;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= step_result;
            end
            else
            begin
                out_reg <= step_result;
            end
        end
    end

    // skid entry only exists behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer holds a result while the output register is empty");

    a_enter_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample.payload.operation == OP_ENTER) |=> (state_reg == STATE_CLEAR))
        else $error("enter-mode transfer did not clear the supervisor state");

    a_verdict_needs_lowv: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.verdict != VERDICT_STAY) |->
        (result.payload.low_voltage &&
         (result.payload.high_load || result.payload.low_current)))
        else $error("nonzero verdict without qualified undervoltage and load flag");

    a_safety_wins: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.low_voltage && result.payload.high_load) |->
        (result.payload.verdict == VERDICT_SAFETY))
        else $error("heavy-load undervoltage did not give safety verdict");

endmodule
